// File: hw/rtl/rotation_matrix_to_quaternion_assert.svh
// Assertion macros shared by the modules of the matrix to quaternion block.
// Every module that includes this file has ports named clock and reset.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

`define RMQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define RMQ_ASSERT_ALWAYS(label, cond, msg) \
   `RMQ_ASSERT_IMPLIES(label, 1'b1, cond, msg)

`endif

// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Magnitudes entering the square sum are kept below 2**30.
   localparam int MAG_BITS  = 30;
   localparam int NSQ_BITS  = 62;
   localparam int ROOT_BITS = 31;

   localparam int FIFO_DEPTH = 2;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_DEGEN = 1'b1
   } status_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } ctl_type;

   // Width of the signed branch vector entries and of their magnitudes.
   function automatic int mag_width(input int dw, input int fb);
      return ((dw > fb + 1) ? dw : fb + 1) + 3;
   endfunction

   // Width of one queued request: four magnitudes, four signs and the status.
   function automatic int item_width(input int dw, input int fb);
      return 4 * mag_width(dw, fb) + 5;
   endfunction

endpackage

// File: hw/rtl/rmq_req_if.sv
interface rmq_req_if #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] m00;
   logic signed [DATA_WIDTH-1:0] m01;
   logic signed [DATA_WIDTH-1:0] m02;
   logic signed [DATA_WIDTH-1:0] m10;
   logic signed [DATA_WIDTH-1:0] m11;
   logic signed [DATA_WIDTH-1:0] m12;
   logic signed [DATA_WIDTH-1:0] m20;
   logic signed [DATA_WIDTH-1:0] m21;
   logic signed [DATA_WIDTH-1:0] m22;

   modport source (
      output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      input  ready
   );

   modport sink (
      input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
      output ready
   );
endinterface

// File: hw/rtl/rmq_rsp_if.sv
interface rmq_rsp_if #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quat_w;
   logic signed [DATA_WIDTH-1:0] quat_x;
   logic signed [DATA_WIDTH-1:0] quat_y;
   logic signed [DATA_WIDTH-1:0] quat_z;
   logic                         status;

   modport source (
      output valid, quat_w, quat_x, quat_y, quat_z, status,
      input  ready
   );

   modport sink (
      input  valid, quat_w, quat_x, quat_y, quat_z, status,
      output ready
   );
endinterface

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter.
// The request channel req_ch carries one 3x3 rotation matrix per request, nine signed
// entries with FRAC_BITS fraction bits. The response channel rsp_ch returns the unit
// quaternion (w, x, y, z) in the same format and a status bit that flags a degenerate
// radicand; the quaternion fields are zero in that case. Both channels transfer on a
// clock edge where valid and ready are high.
// One request can be accepted every cycle while the queue and the classify register
// are not full. Each accepted request passes through one classify stage, one queue
// stage, five stages for pre-shift, squares, sum, exponent and shift, 31 stages of the
// square root (one root bit each), one divider load stage, FRAC_BITS + 2 divider stages
// (one quotient bit each) and the output register.
// When rsp_ch.ready is low while a response is held, the whole back pipeline stalls; the
// two-entry queue and the classify register keep taking requests until they are full,
// then req_ch.ready drops. Reset is synchronous and empties every stage and the queue.
module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);
   localparam int IW = rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS);

   logic          push_valid;
   logic          push_ready;
   logic [IW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [IW-1:0] pop_data;

   rmq_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rmq_fifo #(
      .WIDTH (IW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rmq_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: hw/rtl/rmq_fifo.sv
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_fifo #(
   parameter int WIDTH = rmq_pkg::item_width(rmq_pkg::DATA_WIDTH_DEF, rmq_pkg::FRAC_BITS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = rmq_pkg::FIFO_DEPTH;
   localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RMQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "queue holds more than its depth")
   `RMQ_ASSERT_IMPLIES(a_full_no_pop, (count_ff == CW'(DEPTH)) && !pop, !push, "push into full queue")

endmodule

// File: hw/rtl/rmq_front.sv
module rmq_front #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rmq_req_if.sink req_ch,
   output logic push_valid,
   input  logic push_ready,
   output logic [rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS)-1:0] push_data
);
   localparam int AW = rmq_pkg::mag_width(DATA_WIDTH, FRAC_BITS);
   localparam int IW = rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS);
   localparam logic signed [AW-1:0] ONE_V = AW'(longint'(1) << FRAC_BITS);

   logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [AW-1:0] trace;
   logic signed [AW-1:0] rad;
   logic signed [AW-1:0] vec [0:3];
   logic [3:0][AW-1:0]   mag;
   logic [3:0]           neg;
   rmq_pkg::status_type  status;
   logic                 take;
   logic                 f_valid_ff, f_valid_in;
   logic [IW-1:0]        f_data_ff, f_data_in;

   function automatic logic signed [AW-1:0] sext(input logic [DATA_WIDTH-1:0] v);
      return {{(AW - DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
   endfunction

   always_comb begin
      e00 = sext(req_ch.m00);
      e01 = sext(req_ch.m01);
      e02 = sext(req_ch.m02);
      e10 = sext(req_ch.m10);
      e11 = sext(req_ch.m11);
      e12 = sext(req_ch.m12);
      e20 = sext(req_ch.m20);
      e21 = sext(req_ch.m21);
      e22 = sext(req_ch.m22);
      trace = e00 + e11 + e22;
      if (trace > 0) begin
         rad    = trace + ONE_V;
         vec[0] = rad;
         vec[1] = e21 - e12;
         vec[2] = e02 - e20;
         vec[3] = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         rad    = ONE_V + e00 - e11 - e22;
         vec[0] = e21 - e12;
         vec[1] = rad;
         vec[2] = e01 + e10;
         vec[3] = e02 + e20;
      end else if (e11 > e22) begin
         rad    = ONE_V + e11 - e00 - e22;
         vec[0] = e02 - e20;
         vec[1] = e01 + e10;
         vec[2] = rad;
         vec[3] = e12 + e21;
      end else begin
         rad    = ONE_V + e22 - e00 - e11;
         vec[0] = e10 - e01;
         vec[1] = e02 + e20;
         vec[2] = e12 + e21;
         vec[3] = rad;
      end
      for (int i = 0; i < 4; i++) begin
         neg[i] = vec[i][AW-1];
         mag[i] = neg[i] ? AW'(-vec[i]) : AW'(vec[i]);
      end
      status = (rad <= 0) ? rmq_pkg::STATUS_DEGEN : rmq_pkg::STATUS_OK;
   end

   assign req_ch.ready = !f_valid_ff || push_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign push_valid   = f_valid_ff;
   assign push_data    = f_data_ff;

   always_comb begin
      f_valid_in = req_ch.ready ? req_ch.valid : f_valid_ff;
      f_data_in  = take ? {status, neg, mag} : f_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_data_ff <= f_data_in;
   end

endmodule

// File: hw/rtl/rmq_back.sv
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_back #(
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS)-1:0] pop_data,
   rmq_rsp_if.source rsp_ch
);
   localparam int AW  = rmq_pkg::mag_width(DATA_WIDTH, FRAC_BITS);
   localparam int MB  = rmq_pkg::MAG_BITS;
   localparam int NB  = rmq_pkg::NSQ_BITS;
   localparam int RB  = rmq_pkg::ROOT_BITS;
   localparam int RW  = RB + 3;
   localparam int AIW = $clog2(AW);
   localparam int PW  = $clog2(NB);
   localparam int EW  = $clog2(MB + 1);
   localparam int QW  = FRAC_BITS + 2;
   localparam int NW  = RB + FRAC_BITS + 1;
   localparam int LW  = 64;
   localparam longint ONE_L = longint'(1) << FRAC_BITS;
   localparam longint POS_L = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint HI_L  = (ONE_L < POS_L) ? ONE_L : POS_L;
   localparam longint LO_L  = (ONE_L < POS_L + 1) ? ONE_L : POS_L + 1;
   localparam logic [LW-1:0] HI_U = LW'(HI_L);
   localparam logic [LW-1:0] LO_U = LW'(LO_L);
   localparam logic signed [DATA_WIDTH-1:0] HI_Q = DATA_WIDTH'(HI_L);
   localparam logic signed [DATA_WIDTH-1:0] LO_Q = DATA_WIDTH'(-LO_L);

   logic advance;

   // Pre-shift stage.
   logic [3:0][AW-1:0]   in_mag;
   logic [AW-1:0]        in_or;
   logic [AIW-1:0]       in_msb, in_shift;
   rmq_pkg::ctl_type     s0_ctl_ff, s0_ctl_in;
   logic [3:0]           s0_neg_ff;
   logic [3:0][MB-1:0]   s0_mag_ff, s0_mag_in;

   // Squares, sum and normalizing exponent.
   rmq_pkg::ctl_type     s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [3:0]           s1_neg_ff, s2_neg_ff, s3_neg_ff;
   logic [3:0][MB-1:0]   s1_mag_ff, s2_mag_ff, s3_mag_ff;
   logic [3:0][2*MB-1:0] s1_sqr_ff;
   logic [NB-1:0]        s2_nsq_ff, s2_nsq_in, s3_nsq_ff;
   logic [PW-1:0]        nsq_msb;
   logic [EW-1:0]        s3_exp_ff, s3_exp_in;
   logic [3:0][2*MB:0]   mag_wide;
   logic [3:0][RB-1:0]   mag_sh;

   // Square root pipeline, one root bit per stage.
   rmq_pkg::ctl_type     sq_ctl_ff  [0:RB];
   logic [3:0]           sq_neg_ff  [0:RB];
   logic [3:0][RB-1:0]   sq_mag_ff  [0:RB];
   logic [NB-1:0]        sq_x_ff    [0:RB];
   logic [RW-1:0]        sq_rem_ff  [0:RB];
   logic [RB-1:0]        sq_root_ff [0:RB];
   logic [RW-1:0]        sq_sh      [0:RB-1];
   logic [RW-1:0]        sq_trial   [0:RB-1];
   logic [RW-1:0]        sq_rem_in  [0:RB-1];
   logic [RB-1:0]        sq_root_in [0:RB-1];

   // Divider pipeline, one quotient bit per stage for all four lanes.
   rmq_pkg::ctl_type     dv_ctl_ff  [0:QW];
   logic [3:0]           dv_neg_ff  [0:QW];
   logic [RB-1:0]        dv_n_ff    [0:QW];
   logic [3:0][NW-1:0]   dv_rem_ff  [0:QW];
   logic [3:0][QW-1:0]   dv_q_ff    [0:QW];
   logic [NW-1:0]        dv_dsh     [0:QW-1];
   logic [3:0][NW-1:0]   dv_rem_in  [0:QW-1];
   logic [3:0][QW-1:0]   dv_q_in    [0:QW-1];
   logic [3:0][NW-1:0]   dv_start;

   // Output register.
   rmq_pkg::ctl_type             out_ctl_ff;
   logic [3:0][DATA_WIDTH-1:0]   out_q_ff, out_q_in;
   logic [3:0][LW-1:0]           q_ext, q_sat, q_res;

   assign advance   = !out_ctl_ff.valid || rsp_ch.ready;
   assign pop_ready = advance;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         in_mag[i] = pop_data[i*AW +: AW];
      end
      in_or  = in_mag[0] | in_mag[1] | in_mag[2] | in_mag[3];
      in_msb = '0;
      for (int b = 0; b < AW; b++) begin
         if (in_or[b]) begin
            in_msb = AIW'(b);
         end
      end
      in_shift = (int'(in_msb) >= MB) ? AIW'(int'(in_msb) - (MB - 1)) : '0;
      for (int i = 0; i < 4; i++) begin
         s0_mag_in[i] = MB'(in_mag[i] >> in_shift);
      end
      s0_ctl_in.valid  = pop_valid;
      s0_ctl_in.status = rmq_pkg::status_type'(pop_data[4*AW+4]);
   end

   always_comb begin
      s2_nsq_in = NB'(s1_sqr_ff[0]) + NB'(s1_sqr_ff[1]) + NB'(s1_sqr_ff[2])
                + NB'(s1_sqr_ff[3]);
      nsq_msb = '0;
      for (int b = 0; b < NB; b++) begin
         if (s2_nsq_ff[b]) begin
            nsq_msb = PW'(b);
         end
      end
      s3_exp_in = (int'(nsq_msb) >= NB - 2) ? '0 : EW'((NB - 1 - int'(nsq_msb)) >> 1);
      for (int i = 0; i < 4; i++) begin
         mag_wide[i] = {{(MB + 1){1'b0}}, s3_mag_ff[i]} << s3_exp_ff;
         mag_sh[i]   = mag_wide[i][RB-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < RB; j++) begin
         sq_sh[j]    = {sq_rem_ff[j][RW-3:0], sq_x_ff[j][NB-1 -: 2]};
         sq_trial[j] = {{(RW - RB - 2){1'b0}}, sq_root_ff[j], 2'b01};
         if (sq_sh[j] >= sq_trial[j]) begin
            sq_rem_in[j]  = sq_sh[j] - sq_trial[j];
            sq_root_in[j] = {sq_root_ff[j][RB-2:0], 1'b1};
         end else begin
            sq_rem_in[j]  = sq_sh[j];
            sq_root_in[j] = {sq_root_ff[j][RB-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dv_start[i] = {1'b0, sq_mag_ff[RB][i], {FRAC_BITS{1'b0}}}
                     + NW'(sq_root_ff[RB] >> 1);
      end
      for (int k = 0; k < QW; k++) begin
         dv_dsh[k] = NW'(dv_n_ff[k]) << (QW - 1 - k);
         for (int i = 0; i < 4; i++) begin
            if (dv_rem_ff[k][i] >= dv_dsh[k]) begin
               dv_rem_in[k][i] = dv_rem_ff[k][i] - dv_dsh[k];
               dv_q_in[k][i]   = {dv_q_ff[k][i][QW-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = dv_rem_ff[k][i];
               dv_q_in[k][i]   = {dv_q_ff[k][i][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_ext[i] = LW'(dv_q_ff[QW][i]);
         if (dv_neg_ff[QW][i]) begin
            q_sat[i] = (q_ext[i] > LO_U) ? LO_U : q_ext[i];
            q_res[i] = -q_sat[i];
         end else begin
            q_sat[i] = (q_ext[i] > HI_U) ? HI_U : q_ext[i];
            q_res[i] = q_sat[i];
         end
         out_q_in[i] = (dv_ctl_ff[QW].status == rmq_pkg::STATUS_DEGEN) ?
                       '0 : q_res[i][DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff  <= '0;
         s1_ctl_ff  <= '0;
         s2_ctl_ff  <= '0;
         s3_ctl_ff  <= '0;
         out_ctl_ff <= '0;
         for (int j = 0; j <= RB; j++) begin
            sq_ctl_ff[j] <= '0;
         end
         for (int k = 0; k <= QW; k++) begin
            dv_ctl_ff[k] <= '0;
         end
      end else if (advance) begin
         s0_ctl_ff    <= s0_ctl_in;
         s1_ctl_ff    <= s0_ctl_ff;
         s2_ctl_ff    <= s1_ctl_ff;
         s3_ctl_ff    <= s2_ctl_ff;
         sq_ctl_ff[0] <= s3_ctl_ff;
         for (int j = 0; j < RB; j++) begin
            sq_ctl_ff[j+1] <= sq_ctl_ff[j];
         end
         dv_ctl_ff[0] <= sq_ctl_ff[RB];
         for (int k = 0; k < QW; k++) begin
            dv_ctl_ff[k+1] <= dv_ctl_ff[k];
         end
         out_ctl_ff <= dv_ctl_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_neg_ff <= pop_data[4*AW +: 4];
         s0_mag_ff <= s0_mag_in;

         s1_neg_ff <= s0_neg_ff;
         s1_mag_ff <= s0_mag_ff;
         for (int i = 0; i < 4; i++) begin
            s1_sqr_ff[i] <= s0_mag_ff[i] * s0_mag_ff[i];
         end

         s2_neg_ff <= s1_neg_ff;
         s2_mag_ff <= s1_mag_ff;
         s2_nsq_ff <= s2_nsq_in;

         s3_neg_ff <= s2_neg_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_nsq_ff <= s2_nsq_ff;
         s3_exp_ff <= s3_exp_in;

         sq_neg_ff[0]  <= s3_neg_ff;
         sq_mag_ff[0]  <= mag_sh;
         sq_x_ff[0]    <= s3_nsq_ff << {s3_exp_ff, 1'b0};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         for (int j = 0; j < RB; j++) begin
            sq_neg_ff[j+1]  <= sq_neg_ff[j];
            sq_mag_ff[j+1]  <= sq_mag_ff[j];
            sq_x_ff[j+1]    <= sq_x_ff[j] << 2;
            sq_rem_ff[j+1]  <= sq_rem_in[j];
            sq_root_ff[j+1] <= sq_root_in[j];
         end

         dv_neg_ff[0] <= sq_neg_ff[RB];
         dv_n_ff[0]   <= sq_root_ff[RB];
         dv_rem_ff[0] <= dv_start;
         dv_q_ff[0]   <= '0;
         for (int k = 0; k < QW; k++) begin
            dv_neg_ff[k+1] <= dv_neg_ff[k];
            dv_n_ff[k+1]   <= dv_n_ff[k];
            dv_rem_ff[k+1] <= dv_rem_in[k];
            dv_q_ff[k+1]   <= dv_q_in[k];
         end

         out_q_ff <= out_q_in;
      end
   end

   assign rsp_ch.valid  = out_ctl_ff.valid;
   assign rsp_ch.status = out_ctl_ff.status;
   assign rsp_ch.quat_w = out_q_ff[0];
   assign rsp_ch.quat_x = out_q_ff[1];
   assign rsp_ch.quat_y = out_q_ff[2];
   assign rsp_ch.quat_z = out_q_ff[3];

   `RMQ_ASSERT_IMPLIES(a_degen_zero, rsp_ch.valid && rsp_ch.status == rmq_pkg::STATUS_DEGEN, out_q_ff == '0, "degenerate result carries a nonzero quaternion")
   `RMQ_ASSERT_IMPLIES(a_w_range, rsp_ch.valid && rsp_ch.status == rmq_pkg::STATUS_OK, rsp_ch.quat_w <= HI_Q && rsp_ch.quat_w >= LO_Q, "scalar part outside the unit range")

endmodule
